// ===== src/iou_trk_pkg.sv =====
// ----------------------------------------------------------------------------
// IoU box tracker package
// Types, constants and register map shared by the tracker modules.
// ----------------------------------------------------------------------------
package iou_trk_pkg;

    localparam int MAX_TRACKS   = 256;
    localparam int NUM_CLASSES  = 256;
    localparam int COORD_BITS   = 12;
    localparam int EDGE_DIVISOR = 20;
    localparam int SLOT_BITS    = 8;
    localparam int CLASS_BITS   = 8;
    localparam int OCC_BITS     = 9;
    localparam int TIME_BITS    = 32;
    localparam int AREA_BITS    = 2 * COORD_BITS;
    localparam int UNI_BITS     = AREA_BITS + 1;
    localparam int OV_BITS      = COORD_BITS + 1;
    localparam int MUL_BITS     = UNI_BITS;
    localparam int PROD_BITS    = 2 * MUL_BITS;
    localparam int COUNT_BITS   = 16;
    localparam int EDGE_SHIFT   = 20;
    localparam int EDGE_RECIP   = ((1 << EDGE_SHIFT) + EDGE_DIVISOR - 1) / EDGE_DIVISOR;
    localparam int APB_ADDR_BITS = 5;

    localparam logic [1:0] OP_DETECT    = 2'd0;
    localparam logic [1:0] OP_FRAME_END = 2'd1;
    localparam logic [1:0] OP_READ_CNT  = 2'd2;
    localparam logic [1:0] OP_READ_SLOT = 2'd3;

    localparam int FLAG_VISIBLE = 0;
    localparam int FLAG_FULL    = 1;
    localparam int FLAG_COUNTED = 2;

    localparam logic [2:0] REG_FRAME_WIDTH  = 3'd0;
    localparam logic [2:0] REG_FRAME_HEIGHT = 3'd1;
    localparam logic [2:0] REG_DROP_AFTER   = 3'd2;
    localparam logic [2:0] REG_COUNT_AFTER  = 3'd3;
    localparam logic [2:0] REG_MATCH_THR    = 3'd4;

    typedef struct packed {
        logic [1:0]            opcode;
        logic [TIME_BITS-1:0]  time_ms;
        logic [CLASS_BITS-1:0] in_class;
        logic [COORD_BITS-1:0] in_x;
        logic [COORD_BITS-1:0] in_y;
        logic [COORD_BITS-1:0] in_w;
        logic [COORD_BITS-1:0] in_h;
        logic [SLOT_BITS-1:0]  slot_index;
    } in_item_t;

    typedef struct packed {
        logic [SLOT_BITS-1:0]  track_id;
        logic                  new_track;
        logic                  table_full;
        logic [COUNT_BITS-1:0] count_value;
        logic [OCC_BITS-1:0]   live_tracks;
        logic                  slot_present;
        logic                  slot_visible;
        logic [CLASS_BITS-1:0] slot_class;
        logic [COORD_BITS-1:0] slot_x;
        logic [COORD_BITS-1:0] slot_y;
        logic [COORD_BITS-1:0] slot_w;
        logic [COORD_BITS-1:0] slot_h;
    } out_item_t;

    typedef struct packed {
        logic [11:0] frame_width;
        logic [11:0] frame_height;
        logic [15:0] drop_after_ms;
        logic [15:0] count_after_ms;
        logic [7:0]  match_threshold_q8;
    } cfg_t;

    typedef struct packed {
        logic [CLASS_BITS-1:0] cls;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [COORD_BITS-1:0] w;
        logic [COORD_BITS-1:0] h;
        logic [AREA_BITS-1:0]  area;
        logic [TIME_BITS-1:0]  last_time;
        logic [TIME_BITS-1:0]  first_full;
        logic [2:0]            flags;
    } slot_rec_t;

endpackage

// ===== src/iou_trk_apb_regs.sv =====
// ----------------------------------------------------------------------------
// IoU box tracker configuration registers
// APB-style register file holding the frame size, timing and threshold.
// ----------------------------------------------------------------------------
module iou_trk_apb_regs (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [iou_trk_pkg::APB_ADDR_BITS-1:0] paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready,
    output iou_trk_pkg::cfg_t                    cfg
);

    iou_trk_pkg::cfg_t cfg_reg;
    iou_trk_pkg::cfg_t cfg_next;
    logic              wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (paddr[4:2])
                iou_trk_pkg::REG_FRAME_WIDTH:  cfg_next.frame_width        = pwdata[11:0];
                iou_trk_pkg::REG_FRAME_HEIGHT: cfg_next.frame_height       = pwdata[11:0];
                iou_trk_pkg::REG_DROP_AFTER:   cfg_next.drop_after_ms      = pwdata[15:0];
                iou_trk_pkg::REG_COUNT_AFTER:  cfg_next.count_after_ms     = pwdata[15:0];
                iou_trk_pkg::REG_MATCH_THR:    cfg_next.match_threshold_q8 = pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            iou_trk_pkg::REG_FRAME_WIDTH:  prdata = {20'd0, cfg_reg.frame_width};
            iou_trk_pkg::REG_FRAME_HEIGHT: prdata = {20'd0, cfg_reg.frame_height};
            iou_trk_pkg::REG_DROP_AFTER:   prdata = {16'd0, cfg_reg.drop_after_ms};
            iou_trk_pkg::REG_COUNT_AFTER:  prdata = {16'd0, cfg_reg.count_after_ms};
            iou_trk_pkg::REG_MATCH_THR:    prdata = {24'd0, cfg_reg.match_threshold_q8};
            default:                       prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.frame_width        <= 12'd1920;
            cfg_reg.frame_height       <= 12'd1080;
            cfg_reg.drop_after_ms      <= 16'd250;
            cfg_reg.count_after_ms     <= 16'd500;
            cfg_reg.match_threshold_q8 <= 8'd128;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== src/iou_box_tracker_table_core.sv =====
// ----------------------------------------------------------------------------
// IoU box tracker table core
// Greedy IoU tracker over a table of slots, scanned by a sequencer that
// shares one 25x25 multiplier.
// A detection scans every slot, comparing IoU only against slots of its class
// that overlap it; a frame end visits every slot and bumps the class counter
// for each track newly counted. One transaction is handled at a time.
// Reset is synchronous and clears slot occupancy, counters and the live count.
// ----------------------------------------------------------------------------
module iou_box_tracker_table_core (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  iou_trk_pkg::in_item_t                s_data,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output iou_trk_pkg::out_item_t               m_data,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [iou_trk_pkg::APB_ADDR_BITS-1:0] paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready
);

    localparam int SB  = iou_trk_pkg::SLOT_BITS;
    localparam int CB  = iou_trk_pkg::CLASS_BITS;
    localparam int AB  = iou_trk_pkg::AREA_BITS;
    localparam int UB  = iou_trk_pkg::UNI_BITS;
    localparam int OB  = iou_trk_pkg::OV_BITS;
    localparam int MB  = iou_trk_pkg::MUL_BITS;
    localparam int PB  = iou_trk_pkg::PROD_BITS;
    localparam int KB  = iou_trk_pkg::COUNT_BITS;
    localparam int XB  = iou_trk_pkg::COORD_BITS;
    localparam int NT  = iou_trk_pkg::MAX_TRACKS;
    localparam int NC  = iou_trk_pkg::NUM_CLASSES;

    typedef enum logic [18:0] {
        S_IDLE    = 19'h00001,
        S_DET_AR  = 19'h00002,
        S_DET_RD  = 19'h00004,
        S_DET_CHK = 19'h00008,
        S_DET_MI  = 19'h00010,
        S_DET_UN  = 19'h00020,
        S_DET_MA  = 19'h00040,
        S_DET_MB  = 19'h00080,
        S_DET_CMP = 19'h00100,
        S_DET_THR = 19'h00200,
        S_DET_DEC = 19'h00400,
        S_FE_RD   = 19'h00800,
        S_FE_CHK  = 19'h01000,
        S_FE_CINC = 19'h02000,
        S_CNT_RD  = 19'h04000,
        S_CNT_OUT = 19'h08000,
        S_SL_RD   = 19'h10000,
        S_SL_OUT  = 19'h20000,
        S_EMIT    = 19'h40000
    } state_t;

    iou_trk_pkg::cfg_t      cfg;
    state_t                 state_reg, state_next;
    iou_trk_pkg::in_item_t  item_reg, item_next;
    iou_trk_pkg::out_item_t res_reg, res_next;
    iou_trk_pkg::out_item_t m_data_reg, m_data_next;
    logic                   m_valid_reg, m_valid_next;
    logic [NT-1:0]          used_reg, used_next;
    logic [NC-1:0]          cval_reg, cval_next;
    logic [iou_trk_pkg::OCC_BITS-1:0] occ_reg, occ_next;
    logic [SB-1:0]          idx_reg, idx_next;
    logic                   best_found_reg, best_found_next;
    logic [SB-1:0]          best_idx_reg, best_idx_next;
    logic [AB-1:0]          bi_reg, bi_next;
    logic [UB-1:0]          bu_reg, bu_next;
    logic                   free_found_reg, free_found_next;
    logic [SB-1:0]          free_idx_reg, free_idx_next;
    logic [AB-1:0]          inter_reg, inter_next;
    logic [UB-1:0]          uni_reg, uni_next;
    logic [PB-1:0]          p1_reg, p1_next;
    logic [OB-1:0]          ovx_reg, ovx_next, ovy_reg, ovy_next;
    logic [AB-1:0]          det_area_reg, det_area_next;
    logic                   edge_reg, edge_next;
    logic [CB-1:0]          cls_reg, cls_next;
    logic [PB-1:0]          mul_p_reg;
    logic [MB-1:0]          mul_a, mul_b;

    iou_trk_pkg::slot_rec_t slot_mem [NT];
    iou_trk_pkg::slot_rec_t rd_rec_reg;
    iou_trk_pkg::slot_rec_t slot_wd;
    logic                   slot_we;
    logic [SB-1:0]          slot_wa;

    logic [KB-1:0]          cnt_mem [NC];
    logic [KB-1:0]          cnt_rd_reg;
    logic [CB-1:0]          cnt_ra, cnt_wa;
    logic [KB-1:0]          cnt_wd, cnt_cur;
    logic                   cnt_we;

    logic                   adv_det, adv_fe, last_idx, det_edge, stale, count_ok;
    logic [31:0]            mx_full, my_full;
    logic [XB-1:0]          mx, my;
    logic signed [32:0]     dt_stale, dt_count;
    logic [2:0]             fl;
    logic [XB:0]            hw, hh;

    iou_trk_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    function automatic logic [OB-1:0] overlap(input logic [XB-1:0] c1, input logic [XB-1:0] s1,
                                              input logic [XB-1:0] c2, input logic [XB-1:0] s2);
        logic signed [XB+1:0] l1, r1, l2, r2, lo, hi, d;
        l1 = $signed({2'b00, c1}) - $signed({3'b000, s1[XB-1:1]});
        r1 = l1 + $signed({2'b00, s1});
        l2 = $signed({2'b00, c2}) - $signed({3'b000, s2[XB-1:1]});
        r2 = l2 + $signed({2'b00, s2});
        lo = (l1 > l2) ? l1 : l2;
        hi = (r1 < r2) ? r1 : r2;
        d  = hi - lo;
        return (hi > lo) ? d[OB-1:0] : '0;
    endfunction

    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign last_idx = (idx_reg == SB'(NT - 1));

    assign mx_full = 32'(cfg.frame_width) * 32'(iou_trk_pkg::EDGE_RECIP);
    assign my_full = 32'(cfg.frame_height) * 32'(iou_trk_pkg::EDGE_RECIP);
    assign mx      = mx_full[iou_trk_pkg::EDGE_SHIFT +: XB];
    assign my      = my_full[iou_trk_pkg::EDGE_SHIFT +: XB];
    assign hw      = {2'b00, item_reg.in_w[XB-1:1]};
    assign hh      = {2'b00, item_reg.in_h[XB-1:1]};
    assign det_edge = ({1'b0, item_reg.in_x} < {1'b0, mx} + hw) ||
                      ({1'b0, item_reg.in_x} + hw > {1'b0, cfg.frame_width} - {1'b0, mx}) ||
                      ({1'b0, item_reg.in_y} + hh > {1'b0, cfg.frame_height} - {1'b0, my}) ||
                      ({1'b0, item_reg.in_y} < {1'b0, my} + hh);

    assign dt_stale = $signed({1'b0, item_reg.time_ms}) - $signed({1'b0, rd_rec_reg.last_time});
    assign dt_count = $signed({1'b0, rd_rec_reg.last_time}) - $signed({1'b0, rd_rec_reg.first_full});
    assign stale    = dt_stale > $signed({17'd0, cfg.drop_after_ms});
    assign count_ok = !rd_rec_reg.flags[iou_trk_pkg::FLAG_COUNTED] &&
                      rd_rec_reg.flags[iou_trk_pkg::FLAG_FULL] &&
                      (dt_count > $signed({17'd0, cfg.count_after_ms}));
    assign cnt_cur  = cval_reg[cls_reg] ? cnt_rd_reg : '0;

    always_comb begin
        state_next      = state_reg;
        item_next       = item_reg;
        res_next        = res_reg;
        m_data_next     = m_data_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        used_next       = used_reg;
        cval_next       = cval_reg;
        occ_next        = occ_reg;
        idx_next        = idx_reg;
        best_found_next = best_found_reg;
        best_idx_next   = best_idx_reg;
        bi_next         = bi_reg;
        bu_next         = bu_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        inter_next      = inter_reg;
        uni_next        = uni_reg;
        p1_next         = p1_reg;
        ovx_next        = ovx_reg;
        ovy_next        = ovy_reg;
        det_area_next   = det_area_reg;
        edge_next       = edge_reg;
        cls_next        = cls_reg;
        mul_a           = MB'(item_reg.in_w);
        mul_b           = MB'(item_reg.in_h);
        slot_we         = 1'b0;
        slot_wa         = idx_reg;
        slot_wd         = rd_rec_reg;
        cnt_we          = 1'b0;
        cnt_wa          = cls_reg;
        cnt_wd          = cnt_cur + KB'(1);
        cnt_ra          = item_reg.in_class;
        adv_det         = 1'b0;
        adv_fe          = 1'b0;
        fl              = rd_rec_reg.flags;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    item_next       = s_data;
                    res_next        = '0;
                    best_found_next = 1'b0;
                    free_found_next = 1'b0;
                    best_idx_next   = '0;
                    bi_next         = '0;
                    bu_next         = UB'(1);
                    idx_next        = '0;
                    case (s_data.opcode)
                        iou_trk_pkg::OP_DETECT:    state_next = S_DET_AR;
                        iou_trk_pkg::OP_FRAME_END: state_next = S_FE_RD;
                        iou_trk_pkg::OP_READ_CNT:  state_next = S_CNT_RD;
                        default: begin
                            idx_next   = s_data.slot_index;
                            state_next = S_SL_RD;
                        end
                    endcase
                end
            end
            S_DET_AR: state_next = S_DET_RD;
            S_DET_RD: begin
                if (idx_reg == '0) begin
                    det_area_next = mul_p_reg[AB-1:0];
                end
                if (used_reg[idx_reg]) begin
                    state_next = S_DET_CHK;
                end else begin
                    if (!free_found_reg) begin
                        free_found_next = 1'b1;
                        free_idx_next   = idx_reg;
                    end
                    adv_det = 1'b1;
                end
            end
            S_DET_CHK: begin
                if (rd_rec_reg.cls != item_reg.in_class) begin
                    adv_det = 1'b1;
                end else begin
                    ovx_next   = overlap(rd_rec_reg.x, rd_rec_reg.w, item_reg.in_x, item_reg.in_w);
                    ovy_next   = overlap(rd_rec_reg.y, rd_rec_reg.h, item_reg.in_y, item_reg.in_h);
                    state_next = S_DET_MI;
                end
            end
            S_DET_MI: begin
                mul_a      = MB'(ovx_reg);
                mul_b      = MB'(ovy_reg);
                state_next = S_DET_UN;
            end
            S_DET_UN: begin
                if (mul_p_reg[AB-1:0] == '0) begin
                    adv_det = 1'b1;
                end else begin
                    inter_next = mul_p_reg[AB-1:0];
                    uni_next   = UB'(rd_rec_reg.area) + UB'(det_area_reg) - UB'(mul_p_reg[AB-1:0]);
                    state_next = S_DET_MA;
                end
            end
            S_DET_MA: begin
                mul_a      = MB'(inter_reg);
                mul_b      = MB'(bu_reg);
                state_next = S_DET_MB;
            end
            S_DET_MB: begin
                mul_a      = MB'(bi_reg);
                mul_b      = MB'(uni_reg);
                p1_next    = mul_p_reg;
                state_next = S_DET_CMP;
            end
            S_DET_CMP: begin
                if (p1_reg > mul_p_reg) begin
                    best_found_next = 1'b1;
                    best_idx_next   = idx_reg;
                    bi_next         = inter_reg;
                    bu_next         = uni_reg;
                end
                adv_det = 1'b1;
            end
            S_DET_THR: begin
                mul_a      = MB'(cfg.match_threshold_q8);
                mul_b      = MB'(bu_reg);
                edge_next  = det_edge;
                state_next = S_DET_DEC;
            end
            S_DET_DEC: begin
                slot_wd.cls       = item_reg.in_class;
                slot_wd.x         = item_reg.in_x;
                slot_wd.y         = item_reg.in_y;
                slot_wd.w         = item_reg.in_w;
                slot_wd.h         = item_reg.in_h;
                slot_wd.area      = det_area_reg;
                slot_wd.last_time = item_reg.time_ms;
                if (best_found_reg && (PB'({bi_reg, 8'd0}) > mul_p_reg)) begin
                    slot_we = 1'b1;
                    slot_wa = best_idx_reg;
                    if (!rd_rec_reg.flags[iou_trk_pkg::FLAG_FULL] && !edge_reg) begin
                        fl[iou_trk_pkg::FLAG_FULL] = 1'b1;
                        slot_wd.first_full         = item_reg.time_ms;
                    end
                    slot_wd.flags     = fl;
                    res_next.track_id = best_idx_reg;
                end else if (free_found_reg) begin
                    slot_we                       = 1'b1;
                    slot_wa                       = free_idx_reg;
                    fl                            = '0;
                    fl[iou_trk_pkg::FLAG_VISIBLE] = 1'b1;
                    fl[iou_trk_pkg::FLAG_FULL]    = !edge_reg;
                    slot_wd.flags                 = fl;
                    slot_wd.first_full            = item_reg.time_ms;
                    used_next[free_idx_reg]       = 1'b1;
                    occ_next                      = occ_reg + 1'b1;
                    res_next.track_id             = free_idx_reg;
                    res_next.new_track            = 1'b1;
                end else begin
                    res_next.table_full = 1'b1;
                end
                state_next = S_EMIT;
            end
            S_FE_RD: begin
                if (used_reg[idx_reg]) begin
                    state_next = S_FE_CHK;
                end else begin
                    adv_fe = 1'b1;
                end
            end
            S_FE_CHK: begin
                if (stale) begin
                    used_next[idx_reg] = 1'b0;
                    if (occ_reg != '0) begin
                        occ_next = occ_reg - 1'b1;
                    end
                    adv_fe = 1'b1;
                end else begin
                    fl[iou_trk_pkg::FLAG_VISIBLE] = (item_reg.time_ms == rd_rec_reg.last_time);
                    if (count_ok) begin
                        fl[iou_trk_pkg::FLAG_COUNTED] = 1'b1;
                        cnt_ra     = rd_rec_reg.cls;
                        cls_next   = rd_rec_reg.cls;
                        state_next = S_FE_CINC;
                    end else begin
                        adv_fe = 1'b1;
                    end
                    slot_we       = 1'b1;
                    slot_wd.flags = fl;
                end
            end
            S_FE_CINC: begin
                if (cnt_cur != {KB{1'b1}}) begin
                    cnt_we             = 1'b1;
                    cval_next[cls_reg] = 1'b1;
                end
                adv_fe = 1'b1;
            end
            S_CNT_RD: state_next = S_CNT_OUT;
            S_CNT_OUT: begin
                res_next.count_value = cval_reg[item_reg.in_class] ? cnt_rd_reg : '0;
                state_next           = S_EMIT;
            end
            S_SL_RD: state_next = S_SL_OUT;
            S_SL_OUT: begin
                if (used_reg[idx_reg]) begin
                    res_next.slot_present = 1'b1;
                    res_next.slot_visible = rd_rec_reg.flags[iou_trk_pkg::FLAG_VISIBLE];
                    res_next.slot_class   = rd_rec_reg.cls;
                    res_next.slot_x       = rd_rec_reg.x;
                    res_next.slot_y       = rd_rec_reg.y;
                    res_next.slot_w       = rd_rec_reg.w;
                    res_next.slot_h       = rd_rec_reg.h;
                end
                state_next = S_EMIT;
            end
            S_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    m_data_next             = res_reg;
                    m_data_next.live_tracks = occ_reg;
                    m_valid_next            = 1'b1;
                    state_next              = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        if (adv_det) begin
            if (last_idx) begin
                idx_next   = best_idx_next;
                state_next = S_DET_THR;
            end else begin
                idx_next   = idx_reg + 1'b1;
                state_next = S_DET_RD;
            end
        end
        if (adv_fe) begin
            if (last_idx) begin
                state_next = S_EMIT;
            end else begin
                idx_next   = idx_reg + 1'b1;
                state_next = S_FE_RD;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (slot_we) begin
            slot_mem[slot_wa] <= slot_wd;
        end
        rd_rec_reg <= slot_mem[idx_next];
    end

    always_ff @(posedge aclk) begin
        if (cnt_we) begin
            cnt_mem[cnt_wa] <= cnt_wd;
        end
        cnt_rd_reg <= cnt_mem[cnt_ra];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            used_reg    <= '0;
            cval_reg    <= '0;
            occ_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            used_reg    <= used_next;
            cval_reg    <= cval_next;
            occ_reg     <= occ_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg       <= item_next;
        res_reg        <= res_next;
        m_data_reg     <= m_data_next;
        idx_reg        <= idx_next;
        best_found_reg <= best_found_next;
        best_idx_reg   <= best_idx_next;
        bi_reg         <= bi_next;
        bu_reg         <= bu_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        inter_reg      <= inter_next;
        uni_reg        <= uni_next;
        p1_reg         <= p1_next;
        ovx_reg        <= ovx_next;
        ovy_reg        <= ovy_next;
        det_area_reg   <= det_area_next;
        edge_reg       <= edge_next;
        cls_reg        <= cls_next;
        mul_p_reg      <= mul_a * mul_b;
    end

endmodule

// ===== src/iou_trk_checker.sv =====
// ----------------------------------------------------------------------------
// IoU box tracker port checker
// Concurrent assertions on the tracker's channel ports, bound to the core.
// ----------------------------------------------------------------------------
module iou_trk_checker (
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_valid,
    input logic                   s_ready,
    input iou_trk_pkg::in_item_t  s_data,
    input logic                   m_valid,
    input logic                   m_ready,
    input iou_trk_pkg::out_item_t m_data
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("Result transaction changed before it was taken.");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("Result valid after reset.");

    a_flags_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.new_track && m_data.table_full))
        else $error("New track and table full reported together.");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("Input accepted while a transaction was in progress.");

    a_live_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.live_tracks <= 9'(iou_trk_pkg::MAX_TRACKS))
        else $error("Live track count out of range.");

endmodule

bind iou_box_tracker_table_core iou_trk_checker u_iou_trk_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
